// File: sv/dacw_pkg.sv
// Shared types and constants for the deadline-aware window increase pipeline.
package dacw_pkg;

  localparam logic [31:0] WIN_MAX    = 32'hFFFF_FFFF;
  localparam logic [3:0]  RATE_RESET = 4'd3;
  localparam logic [3:0]  RATE_MIN   = 4'd2;

  typedef enum logic [1:0] {
    CFG_DEADLINE = 2'd0,
    CFG_TOTAL    = 2'd1,
    CFG_RATE     = 2'd2
  } cfg_idx_e;

  // Per-event context that rides along the pipeline.
  typedef struct packed {
    logic [31:0] cur;
    logic [31:0] thr;
    logic [15:0] mss;
    logic [15:0] acked;
    logic [3:0]  rate;
    logic        de;
    logic        nonpos;
    logic        sat;
    logic [31:0] inc_slow;
    logic [36:0] inc_fast;
    logic [20:0] div_fast;
    logic [19:0] boost;
    logic [31:0] msq;
    logic [31:0] wmin;
    logic        below;
    logic        ss;
    logic [36:0] sum;
    logic [20:0] dv;
    logic [31:0] cwnd;
    logic        divz;
    logic [15:0] left;
    logic        ca;
  } dacw_item_t;

endpackage

// File: sv/dacw_div_pipe.sv
// Restoring divider, one quotient bit per register stage, carrying event context.
module dacw_div_pipe import dacw_pkg::*; #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  dacw_item_t       item_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quo_o,
  output dacw_item_t       item_o
);

  logic [DEN_W-1:0] r_q   [NUM_W];
  logic [NUM_W-1:0] n_q   [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  dacw_item_t       item_q[NUM_W];
  logic [NUM_W-1:0] v_q;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] r_in;
    logic [NUM_W-1:0] n_in;
    logic [DEN_W-1:0] den_in;
    dacw_item_t       item_in;
    logic             v_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in    = rem_i;
      assign n_in    = num_i;
      assign den_in  = den_i;
      assign item_in = item_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign r_in    = r_q[k-1];
      assign n_in    = n_q[k-1];
      assign den_in  = den_q[k-1];
      assign item_in = item_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign trial = {r_in, n_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_q[k]    <= {n_in[NUM_W-2:0], ge};
        den_q[k]  <= den_in;
        item_q[k] <= item_in;
      end
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign quo_o   = n_q[NUM_W-1];
  assign item_o  = item_q[NUM_W-1];

endmodule

// File: sv/deadline_aware_cwnd_increase_top.sv
// Top level: deadline-aware congestion window increase, fully pipelined.
// Throughput: one transaction per cycle while the output is not stalled; the three
// bit-serial divider chains (32, 32 and 48 stages) set the depth, not the rate.
// The whole pipeline advances together and holds while a result waits under stall.
// Reset clears all valid bits and loads the registers: deadline off, total 0, rate 3.
module deadline_aware_cwnd_increase_top import dacw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // ACK event input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] cur_window_i,
  input  logic [31:0] start_threshold_i,
  input  logic [15:0] seg_size_i,
  input  logic [15:0] acked_segs_i,
  input  logic [47:0] bytes_sent_i,
  input  logic signed [31:0] time_left_us_i,
  input  logic [31:0] rtt_us_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] new_window_o,
  output logic [31:0] min_window_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        deadline_q;
  logic [47:0] total_q;
  logic [3:0]  rate_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= 1'b0;
      total_q    <= '0;
      rate_q     <= RATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEADLINE: deadline_q <= cfg_data_i[0];
        CFG_TOTAL:    total_q    <= cfg_data_i;
        CFG_RATE:     rate_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Global advance: hold everything only when a finished result is not taken.
  logic out_valid_q;
  logic en;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------------
  // Stage A: capture the event, remaining bytes, small products
  // ---------------------------------------------------------------------------
  logic        a_v_q;
  dacw_item_t  a_item_q, a_item_d;
  logic [47:0] a_rem_q, a_rem_d;
  logic [31:0] a_rtt_q, a_tl_q;
  logic [3:0]  rate_eff;

  assign rate_eff = (rate_q < RATE_MIN) ? RATE_MIN : rate_q;

  always_comb begin
    a_item_d          = '0;
    a_item_d.cur      = cur_window_i;
    a_item_d.thr      = start_threshold_i;
    a_item_d.mss      = seg_size_i;
    a_item_d.acked    = acked_segs_i;
    a_item_d.rate     = rate_eff;
    a_item_d.de       = deadline_q;
    a_item_d.nonpos   = time_left_us_i[31] || (time_left_us_i == 32'sd0);
    a_item_d.inc_slow = seg_size_i * acked_segs_i;
    a_item_d.div_fast = seg_size_i * {rate_eff - 4'd1, 1'b0};
    a_item_d.boost    = seg_size_i * (rate_eff - 4'd1);
    a_rem_d           = (total_q > bytes_sent_i) ? (total_q - bytes_sent_i) : '0;
  end

  // ---------------------------------------------------------------------------
  // Stage B: split 48x32 product, fast-growth and mss^2 products
  // ---------------------------------------------------------------------------
  logic        b_v_q;
  dacw_item_t  b_item_q, b_item_d;
  logic [63:0] b_pl_q;
  logic [47:0] b_ph_q;
  logic [31:0] b_tl_q;

  always_comb begin
    b_item_d          = a_item_q;
    b_item_d.inc_fast = a_item_q.inc_slow * ({a_item_q.rate, 1'b0} - 5'd1);
    b_item_d.msq      = a_item_q.mss * a_item_q.mss;
  end

  // ---------------------------------------------------------------------------
  // Stage C: combine partial products
  // ---------------------------------------------------------------------------
  logic        c_v_q;
  dacw_item_t  c_item_q;
  logic [47:0] c_phi_q;
  logic [31:0] c_plo_q, c_tl_q;

  // ---------------------------------------------------------------------------
  // Stage D: saturation check and divider setup
  // ---------------------------------------------------------------------------
  logic        d_v_q;
  dacw_item_t  d_item_q, d_item_d;
  logic [31:0] d_rem_q, d_num_q, d_den_q;
  logic [31:0] d_rem_d, d_den_d;

  always_comb begin
    d_item_d     = c_item_q;
    d_item_d.sat = (c_phi_q >= {16'd0, c_tl_q});
    d_rem_d      = (d_item_d.sat || c_item_q.nonpos) ? '0 : c_phi_q[31:0];
    d_den_d      = c_item_q.nonpos ? 32'd1 : c_tl_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_item_q <= a_item_d;
      a_rem_q  <= a_rem_d;
      a_rtt_q  <= rtt_us_i;
      a_tl_q   <= time_left_us_i;
      b_item_q <= b_item_d;
      b_pl_q   <= a_rem_q[31:0] * a_rtt_q;
      b_ph_q   <= a_rem_q[47:32] * a_rtt_q;
      b_tl_q   <= a_tl_q;
      c_item_q <= b_item_q;
      c_phi_q  <= b_ph_q + {16'd0, b_pl_q[63:32]};
      c_plo_q  <= b_pl_q[31:0];
      c_tl_q   <= b_tl_q;
      d_item_q <= d_item_d;
      d_rem_q  <= d_rem_d;
      d_num_q  <= c_plo_q;
      d_den_q  <= d_den_d;
    end
  end

  // Divider 1: remaining * rtt / time_left
  logic        q1_v;
  logic [31:0] q1;
  dacw_item_t  q1_item;

  dacw_div_pipe #(.NUM_W(32), .DEN_W(32)) u_div_wmin (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(d_v_q), .rem_i(d_rem_q), .num_i(d_num_q), .den_i(d_den_q),
    .item_i(d_item_q), .valid_o(q1_v), .quo_o(q1), .item_o(q1_item)
  );

  // ---------------------------------------------------------------------------
  // Stage E: pick the minimum window, slow-start growth sum
  // ---------------------------------------------------------------------------
  logic       e_v_q;
  dacw_item_t e_item_q, e_item_d;

  always_comb begin
    e_item_d = q1_item;
    if (!q1_item.de)          e_item_d.wmin = '0;
    else if (q1_item.nonpos)  e_item_d.wmin = q1_item.cur;
    else if (q1_item.sat)     e_item_d.wmin = WIN_MAX;
    else                      e_item_d.wmin = q1;
    e_item_d.ss    = (q1_item.cur < q1_item.thr) && (q1_item.acked != 16'd0);
    e_item_d.below = (q1_item.cur < e_item_d.wmin);
    e_item_d.sum   = {5'd0, q1_item.cur} +
                     (e_item_d.below ? q1_item.inc_fast : {5'd0, q1_item.inc_slow});
    e_item_d.dv    = e_item_d.below ? q1_item.div_fast : {5'd0, q1_item.mss};
  end

  // Stage F: clamp to threshold+1
  logic       f_v_q;
  dacw_item_t f_item_q, f_item_d;
  logic [31:0] cap;

  assign cap = (e_item_q.thr == WIN_MAX) ? WIN_MAX : (e_item_q.thr + 32'd1);

  always_comb begin
    f_item_d = e_item_q;
    if (!e_item_q.ss)                          f_item_d.cwnd = e_item_q.cur;
    else if (e_item_q.sum > {5'd0, e_item_q.thr}) f_item_d.cwnd = cap;
    else                                       f_item_d.cwnd = e_item_q.sum[31:0];
  end

  // Stage G: growth and divisor for the segment count
  logic        g_v_q;
  dacw_item_t  g_item_q, g_item_d;
  logic [31:0] g_num_q;
  logic [20:0] g_den_q;

  always_comb begin
    g_item_d      = f_item_q;
    g_item_d.divz = (f_item_q.dv == 21'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
    end else if (en) begin
      e_v_q <= q1_v;
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_item_q <= e_item_d;
      f_item_q <= f_item_d;
      g_item_q <= g_item_d;
      g_num_q  <= f_item_q.cwnd - f_item_q.cur;
      g_den_q  <= g_item_d.divz ? 21'd1 : f_item_q.dv;
    end
  end

  // Divider 2: segments used by slow start
  logic        q2_v;
  logic [31:0] q2;
  dacw_item_t  q2_item;

  dacw_div_pipe #(.NUM_W(32), .DEN_W(21)) u_div_used (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(g_v_q), .rem_i(21'd0), .num_i(g_num_q), .den_i(g_den_q),
    .item_i(g_item_q), .valid_o(q2_v), .quo_o(q2), .item_o(q2_item)
  );

  // ---------------------------------------------------------------------------
  // Stage H: leftover segments, congestion-avoidance decision
  // ---------------------------------------------------------------------------
  logic       h_v_q;
  dacw_item_t h_item_q, h_item_d;
  logic [31:0] used;

  assign used = q2_item.divz ? 32'd0 : q2;

  always_comb begin
    h_item_d = q2_item;
    if (!q2_item.ss)                         h_item_d.left = q2_item.acked;
    else if ({16'd0, q2_item.acked} > used)  h_item_d.left = q2_item.acked - used[15:0];
    else                                     h_item_d.left = '0;
    h_item_d.below = (q2_item.cwnd < q2_item.wmin);
    h_item_d.ca    = (q2_item.cwnd >= q2_item.thr) && (h_item_d.left != 16'd0);
  end

  // Stage I: mss^2 * left, divisor guard
  logic        i_v_q;
  dacw_item_t  i_item_q;
  logic [47:0] i_num_q;
  logic [31:0] i_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
    end else if (en) begin
      h_v_q <= q2_v;
      i_v_q <= h_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_item_q <= h_item_d;
      i_item_q <= h_item_q;
      i_num_q  <= h_item_q.msq * h_item_q.left;
      i_den_q  <= (h_item_q.cwnd == 32'd0) ? 32'd1 : h_item_q.cwnd;
    end
  end

  // Divider 3: congestion-avoidance increment
  logic        q3_v;
  logic [47:0] q3;
  dacw_item_t  q3_item;

  dacw_div_pipe #(.NUM_W(48), .DEN_W(32)) u_div_add (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(i_v_q), .rem_i(32'd0), .num_i(i_num_q), .den_i(i_den_q),
    .item_i(i_item_q), .valid_o(q3_v), .quo_o(q3), .item_o(q3_item)
  );

  // ---------------------------------------------------------------------------
  // Stage J: increment with floor of one plus boost; stage K: saturate and output
  // ---------------------------------------------------------------------------
  logic        j_v_q;
  dacw_item_t  j_item_q;
  logic [48:0] j_add_q, j_add_d;
  logic [49:0] k_sum;
  logic [31:0] new_window_q, min_window_q;

  always_comb begin
    j_add_d = {1'b0, (q3 == 48'd0) ? 48'd1 : q3} +
              (q3_item.below ? {29'd0, q3_item.boost} : 49'd0);
  end

  assign k_sum = {18'd0, j_item_q.cwnd} + {1'b0, j_add_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      j_v_q       <= q3_v;
      out_valid_q <= j_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      j_item_q     <= q3_item;
      j_add_q      <= j_add_d;
      min_window_q <= j_item_q.wmin;
      if (!j_item_q.ca)               new_window_q <= j_item_q.cwnd;
      else if (k_sum[49:32] != '0)    new_window_q <= WIN_MAX;
      else                            new_window_q <= k_sum[31:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign new_window_o = new_window_q;
  assign min_window_o = min_window_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled while output register is free");

  a_div1_remainder_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_v_q |-> (d_rem_q < d_den_q))
    else $error("minimum-window divider started with remainder not below divisor");

  a_left_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_v_q |-> (h_item_q.left <= h_item_q.acked))
    else $error("leftover segments exceed acknowledged segments");

  // In congestion avoidance the window grows, or a window already at the top stays saturated.
  a_ca_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && j_v_q && j_item_q.ca) |=>
      ((new_window_q > $past(j_item_q.cwnd)) || (new_window_q == WIN_MAX)))
    else $error("congestion avoidance failed to grow the window");

endmodule
